// ----- rtl/block_owner_map_dup_check_unit_macros.svh -----
// Assertion helpers used by the checking code of the block.
`ifndef BLOCK_OWNER_MAP_DUP_CHECK_UNIT_MACROS_SVH
`define BLOCK_OWNER_MAP_DUP_CHECK_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BOMDC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BOMDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bomdc_pkg.sv -----
package bomdc_pkg;

    localparam int BLOCK_W  = 14;
    localparam int LEN_W    = 7;
    localparam int OWNER_W  = 32;
    localparam int RUNLEN_W = 15;
    localparam int CFG_W    = 15;

    localparam logic [CFG_W-1:0] MAX_BLOCK_RESET = 15'd16384;

    // Command codes on the input channel.
    localparam logic [1:0] CMD_MARK_FREE = 2'd0;
    localparam logic [1:0] CMD_CLAIM     = 2'd1;
    localparam logic [1:0] CMD_SCAN      = 2'd2;

    // Work codes passed from the front end to the execution unit.
    localparam logic [1:0] OP_MARK   = 2'd0;
    localparam logic [1:0] OP_CLAIM  = 2'd1;
    localparam logic [1:0] OP_SCAN   = 2'd2;
    localparam logic [1:0] OP_REJECT = 2'd3;

    // Report kinds.
    localparam logic [1:0] KIND_FREE_CONFLICT = 2'd0;
    localparam logic [1:0] KIND_DUP_OWNER     = 2'd1;
    localparam logic [1:0] KIND_RANGE         = 2'd2;
    localparam logic [1:0] KIND_ORPHAN        = 2'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic [1:0]         op;
        logic [BLOCK_W-1:0] block;
        logic [LEN_W-1:0]   length;
        logic [OWNER_W-1:0] owner;
        logic               group_end;
    } t_op;

    typedef struct packed {
        logic [1:0]          kind;
        logic [BLOCK_W-1:0]  block;
        logic [OWNER_W-1:0]  claimant;
        logic [OWNER_W-1:0]  prev_owner;
        logic [RUNLEN_W-1:0] run_length;
        logic [RUNLEN_W-1:0] free_total;
        logic                last;
    } t_result;

endpackage

// ----- rtl/bomdc_intf.sv -----
interface bomdc_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [13:0] block_number;
    logic        is_free;
    logic [6:0]  extent_length;
    logic [31:0] owner_id;
    logic        list_start;
    logic        group_end;

    modport source (
        output valid, command, block_number, is_free, extent_length, owner_id,
               list_start, group_end,
        input  ready
    );
    modport sink (
        input  valid, command, block_number, is_free, extent_length, owner_id,
               list_start, group_end,
        output ready
    );
endinterface

interface bomdc_report_if;
    logic        valid;
    logic        ready;
    logic [1:0]  report_kind;
    logic [13:0] report_block;
    logic [31:0] claimant;
    logic [31:0] previous_owner;
    logic [14:0] run_length;
    logic [14:0] free_total;
    logic        last;

    modport source (
        output valid, report_kind, report_block, claimant, previous_owner, run_length,
               free_total, last,
        input  ready
    );
    modport sink (
        input  valid, report_kind, report_block, claimant, previous_owner, run_length,
               free_total, last,
        output ready
    );
endinterface

// ----- rtl/block_owner_map_dup_check_unit.sv -----
// Block owner map with duplicate and orphan checking.
// Items arrive on i_item (valid/ready); a transfer happens when both are high.
// Results leave on o_report (valid/ready); the last result of an item has last set.
// i_cfg_wr_en/i_cfg_wr_data write the block limit; write only while the block is idle.
// A front end checks each claim against the limit and the skip state of the current
// extent list and passes the work through a four-entry queue to the execution unit,
// which owns the map memory and the output register.
// The execution unit takes one queued item at a time. A mark-free item is a map write,
// a scan a map read, and a claim of L blocks one map read per block and a write for each
// block whose map entry is still empty. A rejected extent waits in the holding register
// for the flush state, which moves the final result of each item to the output register.
// A duplicate waits in the holding register until the next one or the end of its extent.
// After reset the map is cleared one entry per cycle, all BLOCK_COUNT entries in turn;
// i_item.ready stays low during that pass.
// When the receiver holds o_report.ready low, one result waits in the output register
// and one more in a holding register; the execution unit then stops at its next result,
// and the front end keeps taking items until the queue is full.
module block_owner_map_dup_check_unit #(
    parameter int BLOCK_COUNT    = 16384,
    parameter int OWNER_BITS     = 32,
    parameter int MAX_EXTENT_LEN = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [bomdc_pkg::CFG_W-1:0] i_cfg_wr_data,
    bomdc_item_if.sink                  i_item,
    bomdc_report_if.source              o_report
);
    logic           w_clearing;
    logic           w_q_full;
    logic           w_q_empty;
    logic           w_push;
    logic           w_pop;
    bomdc_pkg::t_op w_push_op;
    bomdc_pkg::t_op w_head_op;

    bomdc_front #(
        .BLOCK_COUNT    (BLOCK_COUNT),
        .OWNER_BITS     (OWNER_BITS),
        .MAX_EXTENT_LEN (MAX_EXTENT_LEN)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_item        (i_item),
        .i_clearing    (w_clearing),
        .i_q_full      (w_q_full),
        .o_push        (w_push),
        .o_op          (w_push_op)
    );

    bomdc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_op),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_empty (w_q_empty),
        .o_head  (w_head_op)
    );

    bomdc_back #(
        .BLOCK_COUNT (BLOCK_COUNT),
        .OWNER_BITS  (OWNER_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (w_q_empty),
        .i_q_head   (w_head_op),
        .o_pop      (w_pop),
        .o_clearing (w_clearing),
        .o_report   (o_report)
    );
endmodule

// ----- rtl/bomdc_front.sv -----
module bomdc_front #(
    parameter int BLOCK_COUNT    = 16384,
    parameter int OWNER_BITS     = 32,
    parameter int MAX_EXTENT_LEN = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [bomdc_pkg::CFG_W-1:0]  i_cfg_wr_data,
    bomdc_item_if.sink                   i_item,
    input  logic                         i_clearing,
    input  logic                         i_q_full,
    output logic                         o_push,
    output bomdc_pkg::t_op               o_op
);
    localparam int ADDR_W = $clog2(BLOCK_COUNT);
    localparam int POS_W  = (ADDR_W + 1 > 15) ? ADDR_W + 1 : 15;

    logic [bomdc_pkg::CFG_W-1:0] r_max_block;
    logic                        r_skip;
    logic                        n_skip;
    logic                        w_accept;
    logic                        w_skip_eff;
    logic [POS_W-1:0]            w_end;
    logic [POS_W-1:0]            w_limit;
    logic                        w_bad_range;
    logic                        w_in_table;

    assign i_item.ready = !i_clearing && !i_q_full;
    assign w_accept     = i_item.valid && i_item.ready;

    assign w_skip_eff = i_item.list_start ? 1'b0 : r_skip;
    assign w_end      = POS_W'(i_item.block_number) + POS_W'(i_item.extent_length);
    assign w_limit    = (POS_W'(r_max_block) < POS_W'(BLOCK_COUNT)) ?
                        POS_W'(r_max_block) : POS_W'(BLOCK_COUNT);
    assign w_bad_range = (w_end > w_limit) ||
                         (i_item.extent_length > bomdc_pkg::LEN_W'(MAX_EXTENT_LEN));
    assign w_in_table  = POS_W'(i_item.block_number) < POS_W'(BLOCK_COUNT);

    always_comb begin
        o_op.block     = i_item.block_number;
        o_op.length    = i_item.extent_length;
        o_op.owner     = bomdc_pkg::OWNER_W'(i_item.owner_id[OWNER_BITS-1:0]);
        o_op.group_end = i_item.group_end;
        o_op.op        = bomdc_pkg::OP_SCAN;
        o_push         = 1'b0;
        n_skip         = r_skip;
        if (w_accept) begin
            unique case (i_item.command)
                bomdc_pkg::CMD_MARK_FREE: begin
                    o_op.op = bomdc_pkg::OP_MARK;
                    o_push  = i_item.is_free && w_in_table;
                end
                bomdc_pkg::CMD_CLAIM: begin
                    n_skip = w_skip_eff;
                    if (!w_skip_eff) begin
                        if (w_bad_range) begin
                            o_op.op = bomdc_pkg::OP_REJECT;
                            o_push  = 1'b1;
                            n_skip  = 1'b1;
                        end else begin
                            o_op.op = bomdc_pkg::OP_CLAIM;
                            o_push  = (i_item.extent_length != '0);
                        end
                    end
                end
                bomdc_pkg::CMD_SCAN: begin
                    o_op.op = bomdc_pkg::OP_SCAN;
                    o_push  = 1'b1;
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_block <= bomdc_pkg::MAX_BLOCK_RESET;
            r_skip      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_block <= i_cfg_wr_data;
            end
            r_skip <= n_skip;
        end
    end
endmodule

// ----- rtl/bomdc_queue.sv -----
module bomdc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bomdc_pkg::t_op i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output bomdc_pkg::t_op o_head
);
    bomdc_pkg::t_op                r_slots [bomdc_pkg::QUEUE_DEPTH];
    logic [bomdc_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [bomdc_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [bomdc_pkg::QPTR_W:0]    r_count;

    assign o_full  = (r_count == (bomdc_pkg::QPTR_W + 1)'(bomdc_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slots[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

// ----- rtl/bomdc_back.sv -----
`include "block_owner_map_dup_check_unit_macros.svh"

module bomdc_back #(
    parameter int BLOCK_COUNT = 16384,
    parameter int OWNER_BITS  = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  bomdc_pkg::t_op i_q_head,
    output logic           o_pop,
    output logic           o_clearing,
    bomdc_report_if.source o_report
);
    localparam int ADDR_W = $clog2(BLOCK_COUNT);
    localparam int POS_W  = (ADDR_W + 1 > 15) ? ADDR_W + 1 : 15;
    localparam int CNT_W  = ADDR_W + 1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_CLAIM = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;

    localparam logic [bomdc_pkg::RUNLEN_W-1:0] RUN_LEN_MAX = '1;

    logic [OWNER_BITS-1:0] mem [BLOCK_COUNT];

    logic [2:0]                       r_state,      n_state;
    logic [ADDR_W-1:0]                r_clr_addr,   n_clr_addr;
    bomdc_pkg::t_op                   r_op,         n_op;
    logic [bomdc_pkg::LEN_W-1:0]      r_issue,      n_issue;
    logic                             r_chk_valid,  n_chk_valid;
    logic [POS_W-1:0]                 r_chk_pos,    n_chk_pos;
    logic [CNT_W-1:0]                 r_free_cnt,   n_free_cnt;
    logic [bomdc_pkg::BLOCK_W-1:0]    r_run_start,  n_run_start;
    logic [bomdc_pkg::RUNLEN_W-1:0]   r_run_len,    n_run_len;
    logic                             r_run_open,   n_run_open;
    logic                             r_pend_valid, n_pend_valid;
    bomdc_pkg::t_result               r_pend,       n_pend;
    logic                             r_out_valid,  n_out_valid;
    bomdc_pkg::t_result               r_out,        n_out;
    logic [OWNER_BITS-1:0]            r_rd_data;

    logic                   w_wr_en;
    logic [ADDR_W-1:0]      w_wr_addr;
    logic [OWNER_BITS-1:0]  w_wr_data;
    logic                   w_rd_en;
    logic [ADDR_W-1:0]      w_rd_addr;
    logic                   w_out_free;
    logic [POS_W-1:0]       w_head_pos;
    logic [POS_W-1:0]       w_next_pos;
    logic                   w_dup;
    logic                   w_claim_stall;
    bomdc_pkg::t_result     w_dup_res;
    bomdc_pkg::t_result     w_rej_res;

    logic                             w_unowned;
    logic                             w_extend;
    logic [bomdc_pkg::BLOCK_W-1:0]    w_start1;
    logic [bomdc_pkg::RUNLEN_W-1:0]   w_len1;
    logic                             w_open1;
    logic                             w_emit1;
    logic                             w_emit2;
    bomdc_pkg::t_result               w_r1;
    bomdc_pkg::t_result               w_r2;

    assign o_clearing = (r_state == ST_CLEAR);
    assign w_out_free = !r_out_valid || o_report.ready;
    assign w_head_pos = POS_W'(i_q_head.block);
    assign w_next_pos = POS_W'(r_op.block) + POS_W'(r_issue);
    assign w_dup      = (r_rd_data != '0);
    assign w_claim_stall = r_chk_valid && w_dup && r_pend_valid && !w_out_free;

    always_comb begin
        w_dup_res.kind       = (r_rd_data == OWNER_BITS'(1)) ?
                               bomdc_pkg::KIND_FREE_CONFLICT : bomdc_pkg::KIND_DUP_OWNER;
        w_dup_res.block      = r_chk_pos[bomdc_pkg::BLOCK_W-1:0];
        w_dup_res.claimant   = r_op.owner;
        w_dup_res.prev_owner = bomdc_pkg::OWNER_W'(r_rd_data);
        w_dup_res.run_length = '0;
        w_dup_res.free_total = bomdc_pkg::RUNLEN_W'(r_free_cnt);
        w_dup_res.last       = 1'b0;

        w_rej_res.kind       = bomdc_pkg::KIND_RANGE;
        w_rej_res.block      = i_q_head.block;
        w_rej_res.claimant   = i_q_head.owner;
        w_rej_res.prev_owner = '0;
        w_rej_res.run_length = bomdc_pkg::RUNLEN_W'(i_q_head.length);
        w_rej_res.free_total = bomdc_pkg::RUNLEN_W'(r_free_cnt);
        w_rej_res.last       = 1'b0;
    end

    // Run tracking for a scanned block: the run after the block itself,
    // then the flush requested by the end of a group.
    always_comb begin
        w_unowned = (POS_W'(r_op.block) < POS_W'(BLOCK_COUNT)) && (r_rd_data == '0);
        w_extend  = r_run_open &&
                    ((16'(r_run_start) + 16'(r_run_len)) == 16'(r_op.block));
        w_emit1   = w_unowned && !w_extend && r_run_open;
        w_start1  = r_run_start;
        w_len1    = r_run_len;
        w_open1   = r_run_open;
        if (w_unowned) begin
            w_open1 = 1'b1;
            if (w_extend) begin
                if (r_run_len != RUN_LEN_MAX) begin
                    w_len1 = r_run_len + 1'b1;
                end
            end else begin
                w_start1 = r_op.block;
                w_len1   = bomdc_pkg::RUNLEN_W'(1);
            end
        end
        w_emit2 = r_op.group_end && w_open1;

        w_r1.kind       = bomdc_pkg::KIND_ORPHAN;
        w_r1.block      = r_run_start;
        w_r1.claimant   = '0;
        w_r1.prev_owner = '0;
        w_r1.run_length = r_run_len;
        w_r1.free_total = bomdc_pkg::RUNLEN_W'(r_free_cnt);
        w_r1.last       = 1'b0;

        w_r2            = w_r1;
        w_r2.block      = w_start1;
        w_r2.run_length = w_len1;
    end

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_op         = r_op;
        n_issue      = r_issue;
        n_chk_valid  = r_chk_valid;
        n_chk_pos    = r_chk_pos;
        n_free_cnt   = r_free_cnt;
        n_run_start  = r_run_start;
        n_run_len    = r_run_len;
        n_run_open   = r_run_open;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && !o_report.ready;
        n_out        = r_out;
        o_pop        = 1'b0;
        w_wr_en      = 1'b0;
        w_wr_addr    = r_chk_pos[ADDR_W-1:0];
        w_wr_data    = '0;
        w_rd_en      = 1'b0;
        w_rd_addr    = w_head_pos[ADDR_W-1:0];

        unique case (r_state)
            ST_CLEAR: begin
                w_wr_en    = 1'b1;
                w_wr_addr  = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(BLOCK_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    n_op  = i_q_head;
                    unique case (i_q_head.op)
                        bomdc_pkg::OP_MARK: begin
                            w_wr_en   = 1'b1;
                            w_wr_addr = w_head_pos[ADDR_W-1:0];
                            w_wr_data = OWNER_BITS'(1);
                            if (r_free_cnt < CNT_W'(BLOCK_COUNT)) begin
                                n_free_cnt = r_free_cnt + 1'b1;
                            end
                        end
                        bomdc_pkg::OP_REJECT: begin
                            n_pend_valid = 1'b1;
                            n_pend       = w_rej_res;
                            n_state      = ST_FLUSH;
                        end
                        bomdc_pkg::OP_CLAIM: begin
                            w_rd_en     = 1'b1;
                            n_issue     = bomdc_pkg::LEN_W'(1);
                            n_chk_valid = 1'b1;
                            n_chk_pos   = w_head_pos;
                            n_state     = ST_CLAIM;
                        end
                        default: begin
                            w_rd_en = 1'b1;
                            n_state = ST_SCAN;
                        end
                    endcase
                end
            end
            ST_CLAIM: begin
                // The read of the next block overlaps the check of the current
                // one; blocks within one extent never alias.
                if (!w_claim_stall) begin
                    if (r_chk_valid) begin
                        if (w_dup) begin
                            if (r_pend_valid) begin
                                n_out_valid = 1'b1;
                                n_out       = r_pend;
                            end
                            n_pend_valid = 1'b1;
                            n_pend       = w_dup_res;
                        end else begin
                            w_wr_en   = 1'b1;
                            w_wr_data = r_op.owner[OWNER_BITS-1:0];
                        end
                    end
                    if (r_issue < r_op.length) begin
                        w_rd_en     = 1'b1;
                        w_rd_addr   = w_next_pos[ADDR_W-1:0];
                        n_chk_pos   = w_next_pos;
                        n_chk_valid = 1'b1;
                        n_issue     = r_issue + 1'b1;
                    end else begin
                        n_chk_valid = 1'b0;
                        n_state     = ST_FLUSH;
                    end
                end
            end
            ST_SCAN: begin
                if (!(w_emit1 && w_emit2 && !w_out_free)) begin
                    if (w_emit2) begin
                        n_run_start = '0;
                        n_run_len   = '0;
                        n_run_open  = 1'b0;
                    end else begin
                        n_run_start = w_start1;
                        n_run_len   = w_len1;
                        n_run_open  = w_open1;
                    end
                    if (w_emit1 && w_emit2) begin
                        n_out_valid  = 1'b1;
                        n_out        = w_r1;
                        n_pend_valid = 1'b1;
                        n_pend       = w_r2;
                    end else if (w_emit1) begin
                        n_pend_valid = 1'b1;
                        n_pend       = w_r1;
                    end else if (w_emit2) begin
                        n_pend_valid = 1'b1;
                        n_pend       = w_r2;
                    end
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                // The held result is the final one of its item.
                if (!r_pend_valid) begin
                    n_state = ST_IDLE;
                end else if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out        = r_pend;
                    n_out.last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_chk_pos <= n_chk_pos;
        r_pend    <= n_pend;
        r_out     <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_addr   <= '0;
            r_issue      <= '0;
            r_chk_valid  <= 1'b0;
            r_free_cnt   <= '0;
            r_run_start  <= '0;
            r_run_len    <= '0;
            r_run_open   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_issue      <= n_issue;
            r_chk_valid  <= n_chk_valid;
            r_free_cnt   <= n_free_cnt;
            r_run_start  <= n_run_start;
            r_run_len    <= n_run_len;
            r_run_open   <= n_run_open;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    assign o_report.valid          = r_out_valid;
    assign o_report.report_kind    = r_out.kind;
    assign o_report.report_block   = r_out.block;
    assign o_report.claimant       = r_out.claimant;
    assign o_report.previous_owner = r_out.prev_owner;
    assign o_report.run_length     = r_out.run_length;
    assign o_report.free_total     = r_out.free_total;
    assign o_report.last           = r_out.last;

    `BOMDC_ASSERT_NOW(a_idle_no_pending, i_clk, i_rst_n, r_state == ST_IDLE, !r_pend_valid, "pending result left over in idle")
    `BOMDC_ASSERT_NOW(a_clear_queue_empty, i_clk, i_rst_n, r_state == ST_CLEAR, i_q_empty, "work queued during the clearing pass")
    `BOMDC_ASSERT_NOW(a_claim_issue_bound, i_clk, i_rst_n, r_state == ST_CLAIM, (r_issue <= r_op.length) && (r_op.length != '0), "claim walked past its extent")
    `BOMDC_ASSERT_NEXT(a_pending_kept, i_clk, i_rst_n, r_pend_valid && !w_out_free, r_pend_valid && $stable(r_pend), "held result lost while the output stalled")
endmodule

// ----- tb/bomdc_report_checker.sv -----
module bomdc_report_checker
    import bomdc_pkg::*;
#(
    parameter int BLOCK_COUNT    = 16384,
    parameter int MAX_EXTENT_LEN = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data,
    bomdc_item_if            i_item,
    bomdc_report_if          i_report,
    output int               o_fail_count,
    output int               o_pending
);

    logic [OWNER_W-1:0] owner_map [BLOCK_COUNT];
    logic [CFG_W-1:0]   block_limit;
    int unsigned        free_count;
    logic               skip_list;
    int unsigned        run_begin;
    int unsigned        run_count;
    logic               run_active;
    t_result            expected_reports [$];
    int                 fail_count = 0;

    function automatic t_result make_report(logic [1:0] kind, int unsigned blk,
                                            logic [OWNER_W-1:0] claim,
                                            logic [OWNER_W-1:0] prev, int unsigned len);
        t_result r;
        r.kind       = kind;
        r.block      = blk[BLOCK_W-1:0];
        r.claimant   = claim;
        r.prev_owner = prev;
        r.run_length = len[RUNLEN_W-1:0];
        r.free_total = free_count[RUNLEN_W-1:0];
        r.last       = 1'b0;
        return r;
    endfunction

    // Updates the owner map and the run tracker for one accepted item and
    // queues the reports that the item causes.
    function automatic void predict_reports(logic [1:0] command, logic [BLOCK_W-1:0] blk,
                                            logic is_free, logic [LEN_W-1:0] len,
                                            logic [OWNER_W-1:0] owner, logic list_start,
                                            logic group_end);
        t_result            found [$];
        t_result            tail;
        int unsigned        limit;
        int unsigned        b;
        logic [OWNER_W-1:0] prev;
        case (command)
            CMD_MARK_FREE: begin
                if (is_free) begin
                    owner_map[blk] = OWNER_W'(1);
                    if (free_count < BLOCK_COUNT) free_count++;
                end
            end
            CMD_CLAIM: begin
                limit = (32'(block_limit) < BLOCK_COUNT) ? 32'(block_limit) : BLOCK_COUNT;
                if (list_start) skip_list = 1'b0;
                if (!skip_list) begin
                    if (32'(blk) + 32'(len) > limit || 32'(len) > MAX_EXTENT_LEN) begin
                        found.push_back(make_report(KIND_RANGE, 32'(blk), owner, '0, 32'(len)));
                        skip_list = 1'b1;
                    end else begin
                        for (int i = 0; i < 32'(len); i++) begin
                            b    = 32'(blk) + i;
                            prev = owner_map[b];
                            if (prev != '0) begin
                                found.push_back(make_report(
                                    (prev == OWNER_W'(1)) ? KIND_FREE_CONFLICT : KIND_DUP_OWNER,
                                    b, owner, prev, 0));
                            end else begin
                                owner_map[b] = owner;
                            end
                        end
                    end
                end
            end
            CMD_SCAN: begin
                if (owner_map[blk] == '0) begin
                    if (run_active && run_begin + run_count == 32'(blk)) begin
                        if (run_count < 32'h7FFF) run_count++;
                    end else begin
                        if (run_active) begin
                            found.push_back(make_report(KIND_ORPHAN, run_begin, '0, '0, run_count));
                        end
                        run_begin  = 32'(blk);
                        run_count  = 1;
                        run_active = 1'b1;
                    end
                end
                if (group_end && run_active) begin
                    found.push_back(make_report(KIND_ORPHAN, run_begin, '0, '0, run_count));
                    run_active = 1'b0;
                    run_begin  = 0;
                    run_count  = 0;
                end
            end
            default: begin
            end
        endcase
        if (found.size() > 0) begin
            tail = found[found.size() - 1];
            tail.last = 1'b1;
            found[found.size() - 1] = tail;
            foreach (found[i]) expected_reports.push_back(found[i]);
        end
    endfunction

    function automatic void compare_field(string name, logic [31:0] want_value,
                                          logic [31:0] got_value);
        if (want_value != got_value) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want_value, got_value);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < BLOCK_COUNT; i++) owner_map[i] = '0;
            block_limit = MAX_BLOCK_RESET;
            free_count  = 0;
            skip_list   = 1'b0;
            run_begin   = 0;
            run_count   = 0;
            run_active  = 1'b0;
            expected_reports.delete();
        end else begin
            if (i_report.valid && i_report.ready) begin
                if (expected_reports.size() == 0) begin
                    $error("report transfer with nothing expected: kind %0d block %0d",
                           i_report.report_kind, i_report.report_block);
                    fail_count++;
                end else begin
                    want = expected_reports.pop_front();
                    compare_field("report_kind", 32'(want.kind), 32'(i_report.report_kind));
                    compare_field("report_block", 32'(want.block), 32'(i_report.report_block));
                    compare_field("claimant", want.claimant, i_report.claimant);
                    compare_field("previous_owner", want.prev_owner, i_report.previous_owner);
                    compare_field("run_length", 32'(want.run_length), 32'(i_report.run_length));
                    compare_field("free_total", 32'(want.free_total), 32'(i_report.free_total));
                    compare_field("last", 32'(want.last), 32'(i_report.last));
                end
            end
            if (i_item.valid && i_item.ready) begin
                predict_reports(i_item.command, i_item.block_number, i_item.is_free,
                                i_item.extent_length, i_item.owner_id, i_item.list_start,
                                i_item.group_end);
            end
            if (i_cfg_wr_en) block_limit = i_cfg_wr_data;
        end
        o_pending    <= expected_reports.size();
        o_fail_count <= fail_count;
    end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    import bomdc_pkg::*;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int CYCLE_LIMIT          = 800000;
    localparam int DRAIN_CYCLES         = 400;
    localparam int HOLD_CYCLES          = 400;
    localparam int HOLD_AFTER_ITEMS     = 120;
    localparam int ITEMS_PER_PHASE      = 72;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    int               items_sent  = 0;
    int               scan_cursor = 0;
    int               burst_left  = 0;
    int               cycle_count = 0;
    int               fail_count;
    int               pending;

    bomdc_item_if   item_bus ();
    bomdc_report_if report_bus ();

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    block_owner_map_dup_check_unit uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_item        (item_bus),
        .o_report      (report_bus)
    );

    bomdc_report_checker checker_inst (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_item        (item_bus),
        .i_report      (report_bus),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Drives one item and returns after its transfer. The sender works in bursts; a gap
    // with valid low closes each burst, and the task returns after that gap.
    task automatic send_item(logic [1:0] command, int blk, logic is_free, int len,
                             logic [31:0] owner, logic list_start, logic group_end);
        item_bus.valid         <= 1'b1;
        item_bus.command       <= command;
        item_bus.block_number  <= blk[13:0];
        item_bus.is_free       <= is_free;
        item_bus.extent_length <= len[6:0];
        item_bus.owner_id      <= owner;
        item_bus.list_start    <= list_start;
        item_bus.group_end     <= group_end;
        @(posedge clk);
        while (!item_bus.ready) @(posedge clk);
        items_sent++;
        @(negedge clk);
        burst_left--;
        if (burst_left <= 0) begin
            item_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
        end
    endtask

    // Claims without duplicates give no result, so the block may still be walking
    // the map when the last report arrives; the drain covers a full queue of
    // 64-block extents plus the one in progress.
    task automatic pause_until_idle();
        item_bus.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_limit(int value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[CFG_W-1:0];
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Most traffic stays in a small window so that claims collide often.
    function automatic int pick_block();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return $urandom_range(0, 16383);
        if (r == 1) return $urandom_range(16300, 16383);
        return $urandom_range(0, 767);
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 31);
        if (r == 0) return $urandom_range(65, 127);
        if (r < 3) return $urandom_range(33, 64);
        if (r < 5) return 0;
        return $urandom_range(1, 8);
    endfunction

    function automatic logic [31:0] pick_owner();
        if ($urandom_range(0, 7) == 0) return 32'($urandom_range(2, 5));
        return $urandom;
    endfunction

    task automatic send_random_group();
        int          sel;
        int          count;
        logic [31:0] owner;
        logic        list_start;
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
            // An extent list: the first extent opens it, the rest follow; now and then list_start is drawn at random.
            count = $urandom_range(1, 4);
            owner = pick_owner();
            for (int j = 0; j < count; j++) begin
                list_start = (j == 0);
                if ($urandom_range(0, 9) == 0) list_start = 1'($urandom_range(0, 1));
                send_item(CMD_CLAIM, pick_block(), 1'($urandom_range(0, 1)), pick_length(),
                          owner, list_start, 1'($urandom_range(0, 1)));
            end
        end else if (sel < 65) begin
            send_item(CMD_MARK_FREE, pick_block(), 1'($urandom_range(0, 7) != 0),
                      $urandom_range(0, 127), $urandom, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        end else if (sel < 97) begin
            count = $urandom_range(1, 8);
            case ($urandom_range(0, 7))
                0: scan_cursor = $urandom_range(0, 16383);
                1: scan_cursor = $urandom_range(0, 1023);
                default: begin
                end
            endcase
            for (int j = 0; j < count; j++) begin
                if ($urandom_range(0, 5) == 0) scan_cursor += $urandom_range(1, 4);
                scan_cursor = scan_cursor % 16384;
                send_item(CMD_SCAN, scan_cursor, 1'($urandom_range(0, 1)),
                          $urandom_range(0, 127), $urandom, 1'($urandom_range(0, 1)),
                          (j == count - 1) ? 1'($urandom_range(0, 1))
                                           : 1'($urandom_range(0, 9) == 0));
                scan_cursor++;
            end
        end else begin
            send_item(CMD_UNUSED, $urandom_range(0, 16383), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 127), $urandom, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        end
    endtask

    initial begin : receiver
        int  mode;
        int  span;
        bit  hold_done;
        hold_done = 1'b0;
        forever begin
            if (!hold_done && items_sent >= HOLD_AFTER_ITEMS) begin
                // A long stall while the sender keeps offering items.
                hold_done = 1'b1;
                report_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else begin
                mode = $urandom_range(0, 2);
                span = $urandom_range(10, 60);
                for (int i = 0; i < span; i++) begin
                    case (mode)
                        0: report_bus.ready <= 1'b1;
                        1: report_bus.ready <= 1'($urandom_range(0, 1));
                        default: report_bus.ready <= 1'($urandom_range(0, 3) == 0);
                    endcase
                    @(negedge clk);
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        int limits [5];
        int target;
        limits = '{0, 600, 16383, 16384, 12000};
        item_bus.valid         <= 1'b0;
        item_bus.command       <= CMD_MARK_FREE;
        item_bus.block_number  <= '0;
        item_bus.is_free       <= 1'b0;
        item_bus.extent_length <= '0;
        item_bus.owner_id      <= '0;
        item_bus.list_start    <= 1'b0;
        item_bus.group_end     <= 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        write_limit(16384);

        // Free marks, including one that the bitmap says is in use.
        send_item(CMD_MARK_FREE, 10, 1'b1, 0, 32'd0, 1'b0, 1'b0);
        send_item(CMD_MARK_FREE, 11, 1'b0, 0, 32'd0, 1'b0, 1'b0);
        send_item(CMD_MARK_FREE, 0, 1'b1, 0, 32'd0, 1'b0, 1'b0);
        send_item(CMD_MARK_FREE, 16383, 1'b1, 0, 32'd0, 1'b0, 1'b0);
        // Claims that hit a free block and an owned block.
        send_item(CMD_CLAIM, 8, 1'b0, 6, 32'd5, 1'b1, 1'b0);
        send_item(CMD_CLAIM, 12, 1'b0, 4, 32'd7, 1'b1, 1'b0);
        // Extent past the limit, then the rest of that list is skipped.
        send_item(CMD_CLAIM, 16380, 1'b0, 5, 32'd9, 1'b1, 1'b0);
        send_item(CMD_CLAIM, 100, 1'b0, 3, 32'd9, 1'b0, 1'b0);
        send_item(CMD_CLAIM, 100, 1'b0, 0, 32'd9, 1'b1, 1'b0);
        send_item(CMD_CLAIM, 200, 1'b0, 127, 32'd9, 1'b1, 1'b0);
        send_item(CMD_CLAIM, 300, 1'b0, 64, 32'hFFFF_FFFF, 1'b1, 1'b0);
        // Ends exactly at the limit; claimant zero leaves the entries empty.
        send_item(CMD_CLAIM, 16320, 1'b0, 64, 32'd0, 1'b1, 1'b1);
        send_item(CMD_CLAIM, 400, 1'b0, 2, 32'd1, 1'b1, 1'b0);
        send_item(CMD_CLAIM, 399, 1'b0, 3, 32'd3, 1'b1, 1'b0);
        send_item(CMD_CLAIM, 330, 1'b1, 4, 32'd2, 1'b0, 1'b0);
        // Orphan runs: extend, break on a gap, flush at the end of a group.
        send_item(CMD_SCAN, 1000, 1'b0, 0, 32'd0, 1'b0, 1'b0);
        send_item(CMD_SCAN, 1001, 1'b0, 0, 32'd0, 1'b0, 1'b0);
        send_item(CMD_SCAN, 1003, 1'b0, 0, 32'd0, 1'b0, 1'b0);
        send_item(CMD_SCAN, 1004, 1'b0, 0, 32'd0, 1'b0, 1'b1);
        send_item(CMD_SCAN, 10, 1'b0, 0, 32'd0, 1'b0, 1'b1);
        send_item(CMD_SCAN, 2000, 1'b0, 0, 32'd0, 1'b0, 1'b0);
        send_item(CMD_SCAN, 2005, 1'b0, 0, 32'd0, 1'b0, 1'b1);
        send_item(CMD_SCAN, 16382, 1'b0, 0, 32'd0, 1'b0, 1'b1);
        send_item(CMD_UNUSED, 5, 1'b1, 3, 32'd4, 1'b1, 1'b1);

        foreach (limits[p]) begin
            pause_until_idle();
            write_limit(limits[p]);
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target) send_random_group();
        end
        pause_until_idle();

        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/bomdc_pkg.sv
rtl/bomdc_intf.sv
rtl/bomdc_front.sv
rtl/bomdc_queue.sv
rtl/bomdc_back.sv
rtl/block_owner_map_dup_check_unit.sv
tb/bomdc_report_checker.sv
tb/tb_top.sv
